// ===== rtl/core/jsx_pkg.sv =====
package jsx_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] CharLBrace   = 8'h7B;
  localparam logic [ByteW-1:0] CharRBrace   = 8'h7D;
  localparam logic [ByteW-1:0] CharLBracket = 8'h5B;
  localparam logic [ByteW-1:0] CharRBracket = 8'h5D;
  localparam logic [ByteW-1:0] CharBslash   = 8'h5C;
  localparam logic [ByteW-1:0] CharQuote    = 8'h22;

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_INSIDE = 2'd1,
    PH_TRAIL  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_BRACKET  = 3'd1,
    VERDICT_NONE     = 3'd2,
    VERDICT_UNTERM   = 3'd3,
    VERDICT_OVERFLOW = 3'd4
  } verdict_e;

  // Scanner control state, nesting counters travel separately
  typedef struct packed {
    phase_e   phase;
    logic     in_str;
    logic     esc;
    verdict_e err;
  } ctrl_t;

  typedef struct packed {
    logic             has;
    logic [ByteW-1:0] object_byte;
    logic             byte_present;
    logic             object_done;
    verdict_e         verdict;
  } result_t;

  localparam ctrl_t CtrlReset = '{
    phase:  PH_SEEK,
    in_str: 1'b0,
    esc:    1'b0,
    err:    VERDICT_OK
  };

endpackage

// ===== rtl/core/jsx_in_if.sv =====
interface jsx_in_if
  import jsx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             message_end;

  modport source (output valid, output text_byte, output message_end, input ready);
  modport sink   (input valid, input text_byte, input message_end, output ready);
endinterface

// ===== rtl/core/jsx_out_if.sv =====
interface jsx_out_if
  import jsx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] object_byte;
  logic             byte_present;
  logic             object_done;
  logic [2:0]       verdict;

  modport source (output valid, output object_byte, output byte_present,
                  output object_done, output verdict, input ready);
  modport sink   (input valid, input object_byte, input byte_present,
                  input object_done, input verdict, output ready);
endinterface

// ===== rtl/core/jsx_step.sv =====
module jsx_step
  import jsx_pkg::*;
#(
  parameter int unsigned MAX_NEST = 255,
  parameter int unsigned LvlW     = 8
) (
  input  ctrl_t            ctrl_i,
  input  logic [LvlW-1:0]  brace_i,
  input  logic [LvlW-1:0]  bracket_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             message_end_i,
  output ctrl_t            ctrl_o,
  output logic [LvlW-1:0]  brace_o,
  output logic [LvlW-1:0]  bracket_o,
  output result_t          res_o
);

  localparam logic [LvlW-1:0] MaxLvl = LvlW'(MAX_NEST);
  localparam logic [LvlW-1:0] OneLvl = LvlW'(1);

  logic     closes;
  verdict_e close_verdict;

  always_comb begin
    ctrl_o        = ctrl_i;
    brace_o       = brace_i;
    bracket_o     = bracket_i;
    closes        = 1'b0;
    close_verdict = VERDICT_OK;
    res_o         = '{has: 1'b0, object_byte: '0, byte_present: 1'b0,
                      object_done: 1'b0, verdict: VERDICT_OK};

    case (ctrl_i.phase)
      PH_SEEK: begin
        if (text_byte_i == CharLBrace) begin
          ctrl_o.phase       = PH_INSIDE;
          brace_o            = OneLvl;
          res_o.has          = 1'b1;
          res_o.object_byte  = text_byte_i;
          res_o.byte_present = 1'b1;
          res_o.object_done  = message_end_i;
          res_o.verdict      = message_end_i ? VERDICT_UNTERM : VERDICT_OK;
        end else if (message_end_i) begin
          res_o.has         = 1'b1;
          res_o.object_done = 1'b1;
          res_o.verdict     = VERDICT_NONE;
        end
      end
      PH_INSIDE: begin
        if (ctrl_i.esc) begin
          ctrl_o.esc = 1'b0;
        end else if (ctrl_i.in_str) begin
          if (text_byte_i == CharBslash) begin
            ctrl_o.esc = 1'b1;
          end else if (text_byte_i == CharQuote) begin
            ctrl_o.in_str = 1'b0;
          end
        end else begin
          case (text_byte_i)
            CharQuote: ctrl_o.in_str = 1'b1;
            CharLBrace: begin
              if (brace_i == MaxLvl) begin
                if (ctrl_i.err == VERDICT_OK) ctrl_o.err = VERDICT_OVERFLOW;
              end else begin
                brace_o = brace_i + OneLvl;
              end
            end
            CharRBrace: begin
              if (brace_i != '0) brace_o = brace_i - OneLvl;
              // depth reaches zero from one (or was zero)
              closes = (brace_i <= OneLvl);
            end
            CharLBracket: begin
              if (bracket_i == MaxLvl) begin
                if (ctrl_i.err == VERDICT_OK) ctrl_o.err = VERDICT_OVERFLOW;
              end else begin
                bracket_o = bracket_i + OneLvl;
              end
            end
            CharRBracket: begin
              if (bracket_i == '0) begin
                if (ctrl_i.err == VERDICT_OK) ctrl_o.err = VERDICT_BRACKET;
              end else begin
                bracket_o = bracket_i - OneLvl;
              end
            end
            default: ;
          endcase
        end

        if (ctrl_i.err != VERDICT_OK) begin
          close_verdict = ctrl_i.err;
        end else if (bracket_i != '0) begin
          close_verdict = VERDICT_BRACKET;
        end

        res_o.has          = 1'b1;
        res_o.object_byte  = text_byte_i;
        res_o.byte_present = 1'b1;
        if (closes) begin
          ctrl_o.phase      = PH_TRAIL;
          res_o.object_done = 1'b1;
          res_o.verdict     = close_verdict;
        end else if (message_end_i) begin
          res_o.object_done = 1'b1;
          res_o.verdict     = VERDICT_UNTERM;
        end
      end
      default: ;
    endcase

    // message end returns everything to the start state
    if (message_end_i) begin
      ctrl_o    = CtrlReset;
      brace_o   = '0;
      bracket_o = '0;
    end
  end

endmodule

// ===== rtl/core/json_object_extract_validate.sv =====
// Channel  Dir  Payload                                          Accept
// in_i     in   text_byte[8], message_end[1]                     valid & ready
// out_o    out  object_byte[8], byte_present, object_done,       valid & ready
//               verdict[3]
//
// One byte per cycle while results are taken; a byte passes the byte register
// and the result register. The byte register feeds a combinational scanner,
// so the nesting counters set the only loop, one byte deep.
// Reset (async, active low) empties both registers and clears the scanner.
// A stalled result holds the byte register; a byte that yields no result
// passes regardless of the output side.
module json_object_extract_validate
  import jsx_pkg::*;
#(
  parameter int unsigned MAX_NEST = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsx_in_if.sink    in_i,
  jsx_out_if.source out_o
);

  localparam int unsigned LvlW = $clog2(MAX_NEST + 1);

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;

  ctrl_t            ctrl_q, ctrl_d;
  logic [LvlW-1:0]  brace_q, brace_d;
  logic [LvlW-1:0]  bracket_q, bracket_d;
  result_t          res;

  logic             out_valid_q;
  result_t          out_q;
  logic             advance;

  jsx_step #(
    .MAX_NEST (MAX_NEST),
    .LvlW     (LvlW)
  ) u_step (
    .ctrl_i        (ctrl_q),
    .brace_i       (brace_q),
    .bracket_i     (bracket_q),
    .text_byte_i   (s1_byte_q),
    .message_end_i (s1_last_q),
    .ctrl_o        (ctrl_d),
    .brace_o       (brace_d),
    .bracket_o     (bracket_d),
    .res_o         (res)
  );

  assign advance    = s1_valid_q && (!res.has || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      ctrl_q      <= CtrlReset;
      brace_q     <= '0;
      bracket_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        ctrl_q    <= ctrl_d;
        brace_q   <= brace_d;
        bracket_q <= bracket_d;
      end
      if (advance && res.has) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.text_byte;
      s1_last_q <= in_i.message_end;
    end
    if (advance && res.has) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.object_byte  = out_q.object_byte;
  assign out_o.byte_present = out_q.byte_present;
  assign out_o.object_done  = out_q.object_done;
  assign out_o.verdict      = out_q.verdict;

endmodule

// ===== rtl/core/jsx_checker.sv =====
module jsx_checker
  import jsx_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] object_byte_i,
  input logic             byte_present_i,
  input logic             object_done_i,
  input logic [2:0]       verdict_i
);

  // a result that does not close carries no verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !object_done_i |-> verdict_i == VERDICT_OK)
    else $error("verdict on a result that does not close");

  // a status-only result reports a message with no object
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_present_i |->
      object_done_i && verdict_i == VERDICT_NONE && object_byte_i == '0)
    else $error("malformed status-only result");

  // no-object verdict never comes with a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i == VERDICT_NONE |-> !byte_present_i)
    else $error("no-object verdict with a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(object_byte_i) &&
      $stable(object_done_i) && $stable(verdict_i))
    else $error("stalled result changed");

endmodule

bind json_object_extract_validate jsx_checker u_jsx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .object_byte_i  (out_o.object_byte),
  .byte_present_i (out_o.byte_present),
  .object_done_i  (out_o.object_done),
  .verdict_i      (out_o.verdict)
);
